### hw/rtl/gbsit_pkg.sv
// shared types and constants of the geo box sorted insertion table
`default_nettype none

package gbsit_pkg;

   localparam int LAT_W   = 24;
   localparam int LON_W   = 25;
   localparam int ROW_W   = 16;
   localparam int COL_W   = 16;
   localparam int IDX_W   = 8;
   localparam int STAT_W  = 3;
   localparam int POS_W   = 8;
   localparam int CNT_W   = 9;
   localparam int SCORE_W = 28;
   localparam int SCALE_W = 16;
   // longitude offset from the east edge, 0 .. 5 degrees inside the box
   localparam int D_W     = 19;
   localparam int PROD_W  = D_W + SCALE_W;
   localparam int FRAC_SH = 24;
   localparam int BAND_W  = PROD_W - FRAC_SH;
   localparam int BAND3_W = 12;
   localparam int LOFF_W  = 18;
   localparam int DEG_SH  = 16;

   localparam logic signed [LAT_W-1:0] LAT_MIN = 24'sd2097152;   // 32 deg
   localparam logic signed [LAT_W-1:0] LAT_MAX = 24'sd2293760;   // 35 deg
   localparam logic signed [LON_W-1:0] LON_MIN = -25'sd7929856;  // -121 deg
   localparam logic signed [LON_W-1:0] LON_MAX = -25'sd7602176;  // -116 deg
   localparam logic signed [LON_W:0]   LON_REF = 26'sd7602176;   // 116 deg

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   typedef enum logic [STAT_W-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_OUTSIDE  = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_READ     = 3'd3,
      STAT_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      FN_INSERT = 1'b0,
      FN_READ   = 1'b1
   } func_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic [SCORE_W-1:0]      score;
   } entry_type;

   typedef struct packed {
      logic      ins_en;
      entry_type new_entry;
   } cell_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/gbsit_score.sv
// box check, registered band multiply and sort score
`default_nettype none

module gbsit_score (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic signed [gbsit_pkg::LAT_W-1:0]       lat,
   input  logic signed [gbsit_pkg::LON_W-1:0]       lon,
   input  logic [gbsit_pkg::SCALE_W-1:0]            band_scale,
   output logic [gbsit_pkg::SCORE_W-1:0]            score,
   output logic                                     score_ok
);
   import gbsit_pkg::*;

   logic                    in_box;
   logic signed [LON_W:0]   d_full;
   logic [D_W-1:0]          d;
   logic [PROD_W-1:0]       prod_in;
   logic [LOFF_W-1:0]       loff_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [LOFF_W-1:0]       loff_ff;
   logic                    in_box_ff;
   logic [BAND_W-1:0]       band;
   logic [BAND3_W-1:0]      band3;
   logic signed [LAT_W-1:0] lat_diff;

   assign in_box = (lat >= LAT_MIN) && (lat <= LAT_MAX) &&
                   (lon >= LON_MIN) && (lon <= LON_MAX);

   assign d_full   = -$signed({lon[LON_W-1], lon}) - LON_REF;
   assign d        = d_full[D_W-1:0];
   assign prod_in  = PROD_W'(d) * PROD_W'(band_scale);
   assign lat_diff = lat - LAT_MIN;
   assign loff_in  = lat_diff[LOFF_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff   <= prod_in;
         loff_ff   <= loff_in;
         in_box_ff <= in_box;
      end
   end

   // band times three, then placed at whole degrees
   assign band     = prod_ff[PROD_W-1:FRAC_SH];
   assign band3    = BAND3_W'({band, 1'b0}) + BAND3_W'(band);
   assign score    = {band3, {DEG_SH{1'b0}}} + SCORE_W'(loff_ff);
   assign score_ok = in_box_ff && (score != '0);

endmodule

`default_nettype wire

### hw/rtl/gbsit_cell.sv
// one table cell: holds an entry, compares and shifts up on insert
`default_nettype none

module gbsit_cell #(
   parameter int CELL_IDX = 0,
   parameter int XW       = 9
) (
   input  logic                       clock,
   input  gbsit_pkg::cell_cmd_type    cmd,
   input  logic [XW-1:0]              count_x,
   input  logic [XW-1:0]              rd_idx_x,
   input  gbsit_pkg::entry_type       prev_entry,
   input  logic                       prev_ge,
   output gbsit_pkg::entry_type       entry_o,
   output logic                       ge_o,
   output logic                       pos_hit_o,
   output logic                       rd_hit_o
);
   import gbsit_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      vacant;

   assign vacant    = XW'(CELL_IDX) >= count_x;
   // this cell sits at or above the insert point
   assign ge_o      = vacant || (entry_ff.score > cmd.new_entry.score);
   assign pos_hit_o = ge_o && !prev_ge;
   assign rd_hit_o  = rd_idx_x == XW'(CELL_IDX);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en && ge_o) begin
         if (prev_ge) begin
            entry_in = prev_entry;
         end else begin
            entry_in = cmd.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

`default_nettype wire

### hw/rtl/geo_box_sorted_insert_table_top.sv
// top level of the geo box sorted insertion table
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser func, tdata point or read index
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata position, count, entry
//  csr     | in        | csr_we                | csr_wdata band scale
//
// an item is first captured and run through the band multiply; then the cell row
// compares all scores at once, shifts and loads the result register.
// the next item is taken in the cycle after the result register is loaded.
// reset is synchronous: the entry count clears and the band scale returns to 1.0;
// cell contents are not cleared, so there is no clearing pass.
// a result waiting on rsp_tready holds the row in its exec cycle; one new item is
// still taken while the result register is full.
`default_nettype none

module geo_box_sorted_insert_table_top #(
   parameter int CAPACITY = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // func
   input  logic [95:0]  req_tdata,   // lat, lon, grid_row, grid_col, read_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [127:0] rsp_tdata,   // position, entry_count, out_lat, out_lon, out_row,
                                     // out_col, out_score
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata    // band_scale
);
   import gbsit_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > CNT_W) ? CW : CNT_W;

   state_type state_ff, state_in;

   logic [SCALE_W-1:0]      band_scale_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic                    func_ff;
   logic signed [LAT_W-1:0] lat_ff;
   logic signed [LON_W-1:0] lon_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_ff;
   logic [IDX_W-1:0]        idx_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_stat_ff, rsp_stat_in;
   logic [127:0]            rsp_data_ff, rsp_data_in;

   logic                    accept, fire, out_free;
   logic [SCORE_W-1:0]      score;
   logic                    score_ok;
   logic                    room;
   logic                    ins_ok;
   logic [XW-1:0]           count_x, rd_idx_x, pos_x;
   logic [XW-1:0]           count_in_x;
   entry_type               rd_entry, out_entry;
   cell_cmd_type            cmd;
   logic [POS_W-1:0]        pos_out;
   status_type              stat;

   entry_type               entry_w   [CAPACITY];
   logic [CAPACITY-1:0]     ge_w, pos_hit_w, rd_hit_w;

   gbsit_score u_score (
      .clock      (clock),
      .load       (accept),
      .lat        (req_tdata[23:0]),
      .lon        (req_tdata[48:24]),
      .band_scale (band_scale_ff),
      .score      (score),
      .score_ok   (score_ok)
   );

   assign count_x    = XW'(count_ff);
   assign count_in_x = XW'(count_in);
   assign rd_idx_x   = XW'(idx_ff);
   assign room       = count_ff < CW'(CAPACITY);
   assign ins_ok     = (func_ff == FN_INSERT) && score_ok && room;

   assign cmd.ins_en              = fire && ins_ok;
   assign cmd.new_entry.lat       = lat_ff;
   assign cmd.new_entry.lon       = lon_ff;
   assign cmd.new_entry.row       = row_ff;
   assign cmd.new_entry.col       = col_ff;
   assign cmd.new_entry.score     = score;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         gbsit_cell #(.CELL_IDX(i), .XW(XW)) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count_x    (count_x),
            .rd_idx_x   (rd_idx_x),
            .prev_entry ('0),
            .prev_ge    (1'b0),
            .entry_o    (entry_w[i]),
            .ge_o       (ge_w[i]),
            .pos_hit_o  (pos_hit_w[i]),
            .rd_hit_o   (rd_hit_w[i])
         );
      end else begin : g_body
         gbsit_cell #(.CELL_IDX(i), .XW(XW)) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count_x    (count_x),
            .rd_idx_x   (rd_idx_x),
            .prev_entry (entry_w[i-1]),
            .prev_ge    (ge_w[i-1]),
            .entry_o    (entry_w[i]),
            .ge_o       (ge_w[i]),
            .pos_hit_o  (pos_hit_w[i]),
            .rd_hit_o   (rd_hit_w[i])
         );
      end
   end

   // insert point and read data gathered from the one-hot cell flags
   always_comb begin
      pos_x    = '0;
      rd_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_hit_w[i]) begin
            pos_x = pos_x | XW'(i);
         end
         if (rd_hit_w[i]) begin
            rd_entry = rd_entry | entry_w[i];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      fire       = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_tready = 1'b1;
         FSM_EXEC: fire       = out_free;
         default: begin
            req_tready = 1'b0;
            fire       = 1'b0;
         end
      endcase
   end

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat      = STAT_OUTSIDE;
      pos_out   = '0;
      out_entry = '0;
      count_in  = count_ff;
      if (func_ff == FN_INSERT) begin
         priority if (!score_ok) begin
            stat = STAT_OUTSIDE;
         end else if (!room) begin
            stat = STAT_FULL;
         end else begin
            stat     = STAT_INSERTED;
            pos_out  = pos_x[POS_W-1:0];
            count_in = count_ff + 1'b1;
         end
      end else begin
         pos_out = idx_ff;
         if (rd_idx_x < count_x) begin
            stat      = STAT_READ;
            out_entry = rd_entry;
         end else begin
            stat = STAT_EMPTY;
         end
      end
   end

   assign rsp_stat_in = stat;
   assign rsp_data_in = {2'b00, out_entry.score, out_entry.col, out_entry.row,
                         out_entry.lon, out_entry.lat, count_in_x[CNT_W-1:0], pos_out};
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         band_scale_ff <= SCALE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
         if (csr_we) begin
            band_scale_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_tuser[0];
         lat_ff  <= req_tdata[23:0];
         lon_ff  <= req_tdata[48:24];
         row_ff  <= req_tdata[64:49];
         col_ff  <= req_tdata[80:65];
         idx_ff  <= req_tdata[88:81];
      end
      if (fire) begin
         rsp_stat_ff <= rsp_stat_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_one_insert_point: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXEC) |-> $onehot0(pos_hit_w))
      else $error("more than one insert point in the cell row");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fire && ins_ok) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not advance the entry count");

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == FSM_EXEC))
      else $error("accepted item did not reach the cell row");

endmodule

`default_nettype wire
